/* design/pfml_pkg.sv */
// shared types and constants for the pts floor-match latency table
package pfml_pkg;

  localparam int KEY_W    = 64;
  localparam int TIME_W   = 64;
  localparam int LAT_W    = 32;
  localparam int STATUS_W = 2;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 3;

  localparam logic [KEY_W-1:0]      PTS_INVALID   = '1;
  localparam logic [LAT_W-1:0]      LATENCY_RESET = 32'd5000000;
  // register index taken from paddr[2]
  localparam logic                  REG_MAX_LATENCY = 1'b0;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK      = 2'd0,
    STATUS_NOMATCH = 2'd1,
    STATUS_REJECT  = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    OP_HOLD,
    OP_CMP,
    OP_INS,
    OP_EVI,
    OP_OVR,
    OP_SHL
  } cell_op_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CMP,
    S_REC,
    S_QRY
  } fsm_t;

  // one table entry plus its compare flags against the current key
  typedef struct packed {
    logic [KEY_W-1:0]  key;
    logic [TIME_W-1:0] cap;
    logic              vld;
    logic              le;
    logic              eq;
  } cell_t;

  // command broadcast to every cell
  typedef struct packed {
    cell_op_t          op;
    logic [KEY_W-1:0]  key;
    logic [TIME_W-1:0] cap;
  } cell_cmd_t;

  // left of the first cell acts as a key below everything
  localparam cell_t CELL_EDGE_LEFT  = '{key: '0, cap: '0, vld: 1'b0, le: 1'b1, eq: 1'b0};
  localparam cell_t CELL_EDGE_RIGHT = '{key: '0, cap: '0, vld: 1'b0, le: 1'b0, eq: 1'b0};

endpackage

/* design/pfml_if.sv */
// valid/ready channel interfaces for input and result words
interface pfml_in_if;
  logic        valid;
  logic        ready;
  logic        func;
  logic [63:0] pts;
  logic [63:0] capture_us;
  logic [63:0] now_us;

  modport source (output valid, func, pts, capture_us, now_us, input ready);
  modport sink   (input valid, func, pts, capture_us, now_us, output ready);
endinterface

interface pfml_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [31:0] latency_us;

  modport source (output valid, status, latency_us, input ready);
  modport sink   (input valid, status, latency_us, output ready);
endinterface

/* design/pfml_cell.sv */
// one table cell: holds an entry and trades it with its neighbors
module pfml_cell (
  input  logic              clk,
  input  logic              rst_n,
  input  pfml_pkg::cell_cmd_t cmd,
  input  pfml_pkg::cell_t   left,
  input  pfml_pkg::cell_t   right,
  output pfml_pkg::cell_t   cur
);
  import pfml_pkg::*;

  cell_t cur_r;
  cell_t cur_nxt;
  cell_t fresh;

  assign fresh = '{key: cmd.key, cap: cmd.cap, vld: 1'b1, le: 1'b0, eq: 1'b0};

  always_comb begin
    cur_nxt = cur_r;
    case (cmd.op)
      OP_CMP: begin
        cur_nxt.le = cur_r.vld && (cur_r.key <= cmd.key);
        cur_nxt.eq = cur_r.vld && (cur_r.key == cmd.key);
      end
      OP_INS: begin
        // entries above the key move right, the slot at the boundary takes the new one
        if (!left.le) begin
          cur_nxt = left;
        end else if (!cur_r.le) begin
          cur_nxt = fresh;
        end
      end
      OP_EVI: begin
        // full table: entries at or below the key move left, smallest falls off
        if (right.le) begin
          cur_nxt = right;
        end else if (cur_r.le) begin
          cur_nxt = fresh;
        end
      end
      OP_OVR: begin
        if (cur_r.eq) begin
          cur_nxt.cap = cmd.cap;
        end
      end
      OP_SHL: begin
        cur_nxt = right;
      end
      default: begin
        cur_nxt = cur_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_r.vld <= 1'b0;
      cur_r.le  <= 1'b0;
      cur_r.eq  <= 1'b0;
    end else begin
      cur_r <= cur_nxt;
    end
  end

  assign cur = cur_r;

endmodule

/* design/pfml_cfg.sv */
// apb register holding the maximum accepted latency
module pfml_cfg (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [pfml_pkg::CFG_ADDR_W-1:0]      paddr,
  input  logic [pfml_pkg::CFG_DATA_W-1:0]      pwdata,
  output logic [pfml_pkg::CFG_DATA_W-1:0]      prdata,
  output logic                                 pready,
  output logic [pfml_pkg::LAT_W-1:0]           max_latency
);
  import pfml_pkg::*;

  logic [LAT_W-1:0] max_lat_r;
  logic             hit_reg;

  assign hit_reg = (paddr[2] == REG_MAX_LATENCY);
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_lat_r <= LATENCY_RESET;
    end else if (psel && penable && pwrite && pready && hit_reg) begin
      max_lat_r <= pwdata[LAT_W-1:0];
    end
  end

  assign prdata      = hit_reg ? max_lat_r : '0;
  assign max_latency = max_lat_r;

endmodule

/* design/pts_floor_match_latency_table.sv */
// top level: sorted cell chain of capture times with floor-match latency query
//
// channel   direction  contents
// in_ch     sink       func, pts, capture_us, now_us
// out_ch    source     status, latency_us
// apb       slave      max_latency_us at byte 0
//
// a record word goes through accept, compare in every cell, then update of the chain
// a playout word goes through accept, compare in every cell and a query that drops older entries,
//   as the chain moves left one cell per cycle; an all-ones pts is dropped in its accept cycle
// reset empties the table at once through the cell valid bits
// a held result stalls only the end of a query; no new word is taken while that query waits
module pts_floor_match_latency_table #(
  parameter int TABLE_DEPTH = 512
) (
  input  logic                             clk,
  input  logic                             rst_n,
  pfml_in_if.sink                          in_ch,
  pfml_out_if.source                       out_ch,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [pfml_pkg::CFG_ADDR_W-1:0]  paddr,
  input  logic [pfml_pkg::CFG_DATA_W-1:0]  pwdata,
  output logic [pfml_pkg::CFG_DATA_W-1:0]  prdata,
  output logic                             pready
);
  import pfml_pkg::*;

  fsm_t              state_r, state_nxt;
  logic              func_r;
  logic [KEY_W-1:0]  pts_r;
  logic [TIME_W-1:0] cap_r;
  logic [TIME_W-1:0] now_r;

  logic              out_valid_r;
  status_t           status_r;
  logic [LAT_W-1:0]  lat_r;

  logic [LAT_W-1:0]  max_latency;
  cell_cmd_t         cmd;
  cell_t             cells [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] eq_vec;

  logic              in_fire;
  logic              slot_free;
  logic              hit;
  logic              full;
  logic [TIME_W-1:0] diff;
  logic              lat_ok;
  logic              res_load;
  status_t           res_status;
  logic [LAT_W-1:0]  res_lat;

  pfml_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .max_latency (max_latency)
  );

  for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
    cell_t lft;
    cell_t rgt;
    if (g == 0) begin : g_first
      assign lft = CELL_EDGE_LEFT;
    end else begin : g_mid_l
      assign lft = cells[g-1];
    end
    if (g == TABLE_DEPTH - 1) begin : g_last
      assign rgt = CELL_EDGE_RIGHT;
    end else begin : g_mid_r
      assign rgt = cells[g+1];
    end
    pfml_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .cmd   (cmd),
      .left  (lft),
      .right (rgt),
      .cur   (cells[g])
    );
    assign eq_vec[g] = cells[g].eq;
  end

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign slot_free   = !out_valid_r || out_ch.ready;
  assign hit         = |eq_vec;
  assign full        = cells[TABLE_DEPTH-1].vld;

  assign diff   = now_r - cells[0].cap;
  assign lat_ok = (now_r > cells[0].cap) && (diff < {{(TIME_W-LAT_W){1'b0}}, max_latency});

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_fire && (in_ch.pts != PTS_INVALID)) begin
          state_nxt = S_CMP;
        end
      end
      S_CMP: begin
        state_nxt = func_r ? S_QRY : S_REC;
      end
      S_REC: begin
        state_nxt = S_IDLE;
      end
      S_QRY: begin
        if ((!cells[0].le || !cells[1].le) && slot_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd.op     = OP_HOLD;
    cmd.key    = pts_r;
    cmd.cap    = cap_r;
    res_load   = 1'b0;
    res_status = STATUS_NOMATCH;
    res_lat    = '0;
    case (state_r)
      S_CMP: begin
        cmd.op = OP_CMP;
      end
      S_REC: begin
        if (hit) begin
          cmd.op = OP_OVR;
        end else if (full) begin
          // a key below the whole full table would be evicted at once
          cmd.op = cells[0].le ? OP_EVI : OP_HOLD;
        end else begin
          cmd.op = OP_INS;
        end
      end
      S_QRY: begin
        if (!cells[0].le) begin
          res_load = slot_free;
        end else if (cells[1].le) begin
          cmd.op = OP_SHL;
        end else begin
          res_load = slot_free;
          if (lat_ok) begin
            res_status = STATUS_OK;
            res_lat    = diff[LAT_W-1:0];
          end else begin
            res_status = STATUS_REJECT;
          end
        end
      end
      default: begin
        cmd.op = OP_HOLD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      func_r <= in_ch.func;
      pts_r  <= in_ch.pts;
      cap_r  <= in_ch.capture_us;
      now_r  <= in_ch.now_us;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      status_r <= res_status;
      lat_r    <= res_lat;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.status     = status_r;
  assign out_ch.latency_us = lat_r;

  // a new result only comes out of a query
  a_result_from_query: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_QRY))
    else $error("result raised outside a query");

  // the first two cells stay strictly sorted
  a_head_sorted: assert property (@(posedge clk) disable iff (!rst_n)
    (cells[0].vld && cells[1].vld) |-> (cells[0].key < cells[1].key))
    else $error("head of table out of order");

  // valid entries form a prefix at the head of the chain: a valid second cell needs a valid first
  a_valid_prefix: assert property (@(posedge clk) disable iff (!rst_n)
    cells[1].vld |-> cells[0].vld)
    else $error("hole at head of table");

  // a left shift only drops an entry that has a newer match behind it
  a_shift_keeps_match: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == OP_SHL) |-> (cells[0].le && cells[1].le && cells[1].vld))
    else $error("shift would drop the floor match");

  // latency is zero unless measured
  a_lat_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (status_r != STATUS_OK)) |-> (lat_r == '0))
    else $error("latency set on a non-measured result");

endmodule
